@@ rtl/wpe_pkg.sv @@
// ----------------------------------------------------------------------------
// wpe_pkg
// Shared constants and controller/datapath interface types for the windowed
// percentile estimator.
// ----------------------------------------------------------------------------
`default_nettype none

package wpe_pkg;

  localparam int unsigned DEFAULT_WINDOW = 32;
  localparam int unsigned SAMPLE_W       = 32;
  localparam int unsigned COUNT_W        = 6;

  // floor(n / 10) == (n * 205) >> 11 for every n below 1029
  localparam int unsigned DIV10_MUL      = 205;
  localparam int unsigned DIV10_SHIFT    = 11;

  // controller -> datapath
  typedef struct packed {
    logic accept;     // input transaction taken this cycle
    logic del_step;   // one step of the removal sweep (ascending)
    logic ins_first;  // start of the insertion sweep, read top entry
    logic ins_step;   // one step of the insertion sweep (descending)
    logic ins_zero;   // place the new sample at the bottom entry
    logic sel_read;   // read the entry at the selected rank
    logic sel_load;   // capture the estimate
    logic publish;    // load the output register
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic sample_nz;  // incoming sample is nonzero
    logic full;       // window holds WINDOW samples
    logic del_last;   // removal sweep is at the last entry
    logic ins_empty;  // nothing to shift before insertion
    logic ins_place;  // current entry is not above the new sample
    logic ins_bottom; // insertion sweep is at entry zero
  } dp_sts_t;

endpackage

`default_nettype wire

@@ rtl/wpe_datapath.sv @@
// ----------------------------------------------------------------------------
// wpe_datapath
// Ring window, sorted copy of the window, rank selection and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module wpe_datapath #(
  parameter int unsigned WINDOW = wpe_pkg::DEFAULT_WINDOW
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [wpe_pkg::SAMPLE_W-1:0]  duration_sample_i,
  input  wire wpe_pkg::dp_cmd_t              cmd_i,
  output wpe_pkg::dp_sts_t                   sts_o,
  output logic      [wpe_pkg::SAMPLE_W-1:0]  work_estimate_o,
  output logic                               sample_taken_o,
  output logic      [wpe_pkg::COUNT_W-1:0]   valid_count_o
);
  import wpe_pkg::*;

  localparam int unsigned IDX_W = $clog2(WINDOW);
  localparam int unsigned CNT_W = $clog2(WINDOW + 1);
  localparam int unsigned MUL_W = CNT_W + 12;

  localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(WINDOW - 1);
  localparam logic [CNT_W-1:0] FULL_CNT   = CNT_W'(WINDOW);
  localparam logic [MUL_W-1:0] DIV10_K    = MUL_W'(DIV10_MUL);

  // ring window, in arrival order
  logic [SAMPLE_W-1:0] ring_mem [WINDOW];
  // same samples, ascending
  logic [SAMPLE_W-1:0] sort_mem [WINDOW];

  logic [SAMPLE_W-1:0] x_q;
  logic [SAMPLE_W-1:0] evict_q;
  logic [SAMPLE_W-1:0] s_rd_q;
  logic [SAMPLE_W-1:0] est_q, est_d;
  logic                taken_q;
  logic [CNT_W-1:0]    n_q, n_d;
  logic [IDX_W-1:0]    slot_q, slot_d;
  logic [IDX_W-1:0]    k_q, k_d;
  logic [IDX_W-1:0]    len_q;
  logic                found_q, found_d;

  logic [SAMPLE_W-1:0] out_est_q;
  logic                out_taken_q;
  logic [COUNT_W-1:0]  out_cnt_q;

  logic                sample_nz;
  logic                full;
  logic                take;

  logic                s_rd_en;
  logic [IDX_W-1:0]    s_raddr;
  logic                s_we;
  logic [IDX_W-1:0]    s_waddr;
  logic [SAMPLE_W-1:0] s_wdata;

  logic [MUL_W-1:0]    div_prod;
  logic [CNT_W-1:0]    tenth;
  logic [CNT_W-1:0]    drop;
  logic [CNT_W-1:0]    rank_cnt;
  logic [CNT_W+COUNT_W-1:0] cnt_ext;

  assign sample_nz = (duration_sample_i != '0);
  assign full      = (n_q == FULL_CNT);
  assign take      = cmd_i.accept && sample_nz;

  // rank = n - 1 - max(1, n/10) for n > 1, 0 for n == 1
  assign div_prod = MUL_W'(n_q) * DIV10_K;
  assign tenth    = div_prod[DIV10_SHIFT +: CNT_W];
  assign drop     = (tenth == '0) ? CNT_W'(1) : tenth;
  assign rank_cnt = (n_q == CNT_W'(1)) ? '0 : (n_q - drop - CNT_W'(1));

  assign cnt_ext  = {{COUNT_W{1'b0}}, n_q};

  // sorted memory port control
  always_comb begin
    s_rd_en = 1'b0;
    s_raddr = '0;
    s_we    = 1'b0;
    s_waddr = '0;
    s_wdata = x_q;
    if (take) begin
      s_rd_en = 1'b1;
    end
    if (cmd_i.del_step) begin
      s_rd_en = (k_q != LAST_IDX);
      s_raddr = k_q + IDX_W'(1);
      // once the evicted value is passed, everything moves down one entry
      s_we    = found_q;
      s_waddr = k_q - IDX_W'(1);
      s_wdata = s_rd_q;
    end
    if (cmd_i.ins_first) begin
      s_rd_en = 1'b1;
      s_raddr = len_q - IDX_W'(1);
    end
    if (cmd_i.ins_step) begin
      s_rd_en = !sts_o.ins_place && (k_q != '0);
      s_raddr = k_q - IDX_W'(1);
      s_we    = 1'b1;
      s_waddr = k_q + IDX_W'(1);
      s_wdata = sts_o.ins_place ? x_q : s_rd_q;
    end
    if (cmd_i.ins_zero) begin
      s_we    = 1'b1;
      s_waddr = '0;
      s_wdata = x_q;
    end
    if (cmd_i.sel_read) begin
      s_rd_en = 1'b1;
      s_raddr = rank_cnt[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_we) begin
      sort_mem[s_waddr] <= s_wdata;
    end
    if (s_rd_en) begin
      s_rd_q <= sort_mem[s_raddr];
    end
  end

  // ring write and eviction read share the accept cycle; read sees old data
  always_ff @(posedge clk_i) begin
    if (take) begin
      ring_mem[slot_q] <= duration_sample_i;
      evict_q          <= ring_mem[slot_q];
    end
  end

  always_comb begin
    n_d     = n_q;
    slot_d  = slot_q;
    k_d     = k_q;
    found_d = found_q;
    est_d   = est_q;
    if (take) begin
      n_d     = full ? n_q : (n_q + CNT_W'(1));
      slot_d  = (slot_q == LAST_IDX) ? '0 : (slot_q + IDX_W'(1));
      k_d     = '0;
      found_d = 1'b0;
    end
    if (cmd_i.del_step) begin
      k_d = k_q + IDX_W'(1);
      if (!found_q && (s_rd_q == evict_q)) begin
        found_d = 1'b1;
      end
    end
    if (cmd_i.ins_first) begin
      k_d = len_q - IDX_W'(1);
    end
    if (cmd_i.ins_step) begin
      k_d = k_q - IDX_W'(1);
    end
    if (cmd_i.sel_load) begin
      est_d = s_rd_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q     <= '0;
      slot_q  <= '0;
      k_q     <= '0;
      found_q <= 1'b0;
      est_q   <= '0;
      taken_q <= 1'b0;
    end else begin
      n_q     <= n_d;
      slot_q  <= slot_d;
      k_q     <= k_d;
      found_q <= found_d;
      est_q   <= est_d;
      if (cmd_i.accept) begin
        taken_q <= sample_nz;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      x_q   <= duration_sample_i;
      len_q <= full ? LAST_IDX : n_q[IDX_W-1:0];
    end
    if (cmd_i.publish) begin
      out_est_q   <= est_q;
      out_taken_q <= taken_q;
      out_cnt_q   <= cnt_ext[COUNT_W-1:0];
    end
  end

  assign sts_o.sample_nz  = sample_nz;
  assign sts_o.full       = full;
  assign sts_o.del_last   = (k_q == LAST_IDX);
  assign sts_o.ins_empty  = (len_q == '0);
  assign sts_o.ins_place  = (s_rd_q <= x_q);
  assign sts_o.ins_bottom = (k_q == '0);

  assign work_estimate_o = out_est_q;
  assign sample_taken_o  = out_taken_q;
  assign valid_count_o   = out_cnt_q;

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= FULL_CNT)
    else $error("held sample count above window size");

  a_rank_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.sel_read |-> (rank_cnt < n_q))
    else $error("selected rank outside the held samples");

  a_evict_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.del_step && sts_o.del_last) |-> (found_q || (s_rd_q == evict_q)))
    else $error("evicted sample missing from sorted window");

endmodule

`default_nettype wire

@@ rtl/wpe_ctrl.sv @@
// ----------------------------------------------------------------------------
// wpe_ctrl
// Sequencer: accepts a transaction; for a nonzero sample runs the removal
// (window full) and insertion sweeps, selects the rank; hands the result out.
// ----------------------------------------------------------------------------
`default_nettype none

module wpe_ctrl (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  wire logic         out_stall_i,
  input  wire wpe_pkg::dp_sts_t sts_i,
  output wpe_pkg::dp_cmd_t  cmd_o
);
  import wpe_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DEL  = 3'd1;
  localparam logic [2:0] ST_INSP = 3'd2;
  localparam logic [2:0] ST_INS  = 3'd3;
  localparam logic [2:0] ST_INSZ = 3'd4;
  localparam logic [2:0] ST_SEL  = 3'd5;
  localparam logic [2:0] ST_SELW = 3'd6;
  localparam logic [2:0] ST_PUB  = 3'd7;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (!sts_i.sample_nz) begin
            state_d = ST_PUB;
          end else if (sts_i.full) begin
            state_d = ST_DEL;
          end else begin
            state_d = ST_INSP;
          end
        end
      end
      ST_DEL: begin
        cmd_o.del_step = 1'b1;
        if (sts_i.del_last) begin
          state_d = ST_INSP;
        end
      end
      ST_INSP: begin
        if (sts_i.ins_empty) begin
          cmd_o.ins_zero = 1'b1;
          state_d        = ST_SEL;
        end else begin
          cmd_o.ins_first = 1'b1;
          state_d         = ST_INS;
        end
      end
      ST_INS: begin
        cmd_o.ins_step = 1'b1;
        if (sts_i.ins_place) begin
          state_d = ST_SEL;
        end else if (sts_i.ins_bottom) begin
          state_d = ST_INSZ;
        end
      end
      ST_INSZ: begin
        cmd_o.ins_zero = 1'b1;
        state_d        = ST_SEL;
      end
      ST_SEL: begin
        cmd_o.sel_read = 1'b1;
        state_d        = ST_SELW;
      end
      ST_SELW: begin
        cmd_o.sel_load = 1'b1;
        state_d        = ST_PUB;
      end
      ST_PUB: begin
        if (out_free) begin
          cmd_o.publish = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (cmd_o.publish) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

  a_publish_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.publish |-> (!out_valid_q || !out_stall_i))
    else $error("output register overwritten while occupied");

  a_publish_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.publish |=> out_valid_q)
    else $error("published result not presented");

  a_sample_sweeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.accept && sts_i.sample_nz) |=> ((state_q == ST_DEL) || (state_q == ST_INSP)))
    else $error("nonzero sample skipped the window update");

endmodule

`default_nettype wire

@@ rtl/windowed_percentile_estimator_top.sv @@
// ----------------------------------------------------------------------------
// windowed_percentile_estimator_top
// Sliding-window order statistic over the last WINDOW nonzero duration
// samples; reports roughly the 90th-percentile value per transaction.
// ----------------------------------------------------------------------------
//   channel  direction  handshake                 payload
//   in       sink       in_valid_i / in_stall_o   duration_sample_i
//   out      source     out_valid_o / out_stall_i work_estimate_o, sample_taken_o,
//                                                 valid_count_o
//
// One transaction at a time. A zero sample goes straight to the output
// register. A nonzero sample runs an insertion sweep, preceded once the window
// is full by a removal sweep, over the sorted copy, one entry per cycle
// through its one read port and one write port.
// Reset clears count, write slot and estimate; the window memories need none.
// A stalled output holds the result; the next input is taken meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module windowed_percentile_estimator_top #(
  parameter int unsigned WINDOW = wpe_pkg::DEFAULT_WINDOW
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [wpe_pkg::SAMPLE_W-1:0]  duration_sample_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic      [wpe_pkg::SAMPLE_W-1:0]  work_estimate_o,
  output logic                               sample_taken_o,
  output logic      [wpe_pkg::COUNT_W-1:0]   valid_count_o
);
  import wpe_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  wpe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  wpe_datapath #(
    .WINDOW (WINDOW)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .duration_sample_i (duration_sample_i),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .work_estimate_o   (work_estimate_o),
    .sample_taken_o    (sample_taken_o),
    .valid_count_o     (valid_count_o)
  );

endmodule

`default_nettype wire
